### rtl/cpd_pkg.sv
// Shared types and constants for the camera packet deframer.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package cpd_pkg;

    // Header constants
    localparam logic [11:0] HDR_BYTES = 12'd12;
    localparam logic [7:0]  MAGIC_A   = 8'h52;   // 'R'
    localparam logic [7:0]  MAGIC_B   = 8'h42;   // 'B'
    localparam logic [7:0]  MAX_SKIP  = 8'd5;

    // Flag bits ORed into the base stream flag
    localparam logic [7:0] FLAG_SOF = 8'h01;
    localparam logic [7:0] FLAG_MOF = 8'h02;
    localparam logic [7:0] FLAG_EOF = 8'h05;

    // Configuration register indexes and reset values
    localparam logic [1:0] CFG_STREAM_FLAG   = 2'd0;
    localparam logic [1:0] CFG_FRAME_PACKETS = 2'd1;
    localparam logic [1:0] CFG_PAYLOAD_SIZE  = 2'd2;

    localparam logic [7:0]  RST_STREAM_FLAG   = 8'h70;
    localparam logic [11:0] RST_FRAME_PACKETS = 12'd242;
    localparam logic [11:0] RST_PAYLOAD_SIZE  = 12'd1760;

    typedef enum logic [2:0] {
        ST_SHORT     = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_UNSYNCED  = 3'd2,
        ST_LOST      = 3'd3,
        ST_FLAG      = 3'd4,
        ST_OVERSIZE  = 3'd5,
        ST_ACCEPTED  = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0]  stream_flag;
        logic [11:0] frame_packets;
        logic [11:0] payload_size;
    } t_cfg;

    typedef struct packed {
        logic [31:0] packet_timestamp;
        logic [7:0]  seq_number;
        logic [7:0]  flag_byte;
        logic [7:0]  magic_second;
        logic [7:0]  magic_first;
        logic [11:0] packet_length;
    } t_item;

    // Decision result; position is zero unless the packet is accepted
    typedef struct packed {
        t_status     status;
        logic [11:0] position;
        logic [11:0] payload_length;
        logic        frame_done;
        logic [11:0] frame_packets_received;
        logic [31:0] frame_timestamp;
    } t_result;

endpackage

`default_nettype wire

### rtl/camera_packet_deframer.sv
// Top level of the camera packet deframer: input register and stage wiring.
// Depends on cpd_pkg, cpd_cfg, cpd_core and cpd_out.
//
//   channel   dir   handshake                  payload
//   s_*       in    s_tvalid / s_tready        s_tdata header fields, s_tuser flag byte
//   m_*       out   m_tvalid / m_tready        m_tdata placement, m_tuser status, m_tlast done
//   i_cfg_*   in    i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One header beat per cycle sustained while m_tready is high; a result reaches m_* via the
// input register, then decision and state update, then offset multiply.
// The per-packet state update is compare-and-add logic in a single stage, so beats
// may follow each other with no gap. Reset is synchronous, active low, and clears
// sync, counters and all valid flags. A stall on m_tready backs up through the
// stages; each stage holds one beat, so up to three beats are buffered.
`default_nettype none

module camera_packet_deframer
    import cpd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // packet_length, magic_first, magic_second,
                                        // seq_number, packet_timestamp
    input  wire logic [7:0]  s_tuser,   // flag_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // write_offset, payload_length,
                                        // frame_packets_received, frame_timestamp
    output logic [2:0]       m_tuser,   // status
    output logic             m_tlast,   // frame_done
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [11:0] i_cfg_data
);

    t_cfg    cfg;
    logic    r_in_valid;
    t_item   r_in_item;
    logic    core_ready;
    logic    res_valid;
    t_result res;
    logic    out_ready;

    assign s_tready = !r_in_valid || core_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_item.packet_length    <= s_tdata[11:0];
            r_in_item.magic_first      <= s_tdata[19:12];
            r_in_item.magic_second     <= s_tdata[27:20];
            r_in_item.seq_number       <= s_tdata[35:28];
            r_in_item.packet_timestamp <= s_tdata[67:36];
            r_in_item.flag_byte        <= s_tuser;
        end
    end

    cpd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    cpd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (r_in_valid),
        .i_item      (r_in_item),
        .o_ready     (core_ready),
        .i_out_ready (out_ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    cpd_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (res_valid),
        .i_res    (res),
        .o_ready  (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### rtl/cpd_cfg.sv
// Configuration registers of the camera packet deframer.
// Depends on cpd_pkg for register indexes and reset values.
`default_nettype none

module cpd_cfg
    import cpd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [11:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    // Register write decode; writes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stream_flag   <= RST_STREAM_FLAG;
            r_cfg.frame_packets <= RST_FRAME_PACKETS;
            r_cfg.payload_size  <= RST_PAYLOAD_SIZE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STREAM_FLAG:   r_cfg.stream_flag   <= i_cfg_data[7:0];
                CFG_FRAME_PACKETS: r_cfg.frame_packets <= i_cfg_data;
                CFG_PAYLOAD_SIZE:  r_cfg.payload_size  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/cpd_core.sv
// Sync tracking, loss skipping and frame position logic with its result register.
// Depends on cpd_pkg for the item, result and configuration types.
`default_nettype none

module cpd_core
    import cpd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_cfg      i_cfg,
    input  wire logic i_valid,
    input  t_item     i_item,
    output logic      o_ready,
    input  wire logic i_out_ready,
    output logic      o_res_valid,
    output t_result   o_res
);

    // Tracking state
    logic        r_sync;
    logic [7:0]  r_exp;
    logic [11:0] r_pos;
    logic [11:0] r_rcv;
    logic [11:0] r_cmp;
    logic [31:0] r_prev_ts;
    logic [31:0] r_cmp_ts;

    logic        n_sync;
    logic [7:0]  n_exp;
    logic [11:0] n_pos;
    logic [11:0] n_rcv;
    logic [11:0] n_cmp;
    logic [31:0] n_prev_ts;
    logic [31:0] n_cmp_ts;

    logic        r_res_valid;
    t_result     r_res;
    t_result     n_res;

    logic        take;
    logic [7:0]  sof;
    logic [7:0]  mof;
    logic [7:0]  eof;

    assign sof = i_cfg.stream_flag | FLAG_SOF;
    assign mof = i_cfg.stream_flag | FLAG_MOF;
    assign eof = i_cfg.stream_flag | FLAG_EOF;

    assign o_ready = !r_res_valid || i_out_ready;
    assign take    = i_valid && o_ready;

    // Per-packet decision and next state
    always_comb begin
        logic        go;
        logic        closed;
        logic        ok;
        logic [7:0]  e_exp;
        logic [11:0] e_pos;
        logic [11:0] e_rcv;
        logic [11:0] e_cmp;
        logic [31:0] e_cmp_ts;
        logic [7:0]  lost;
        logic [12:0] pos_lost;
        logic [12:0] pos_inc;
        logic [12:0] fp_wide;
        logic [11:0] dlen;

        n_sync    = r_sync;
        n_exp     = r_exp;
        n_pos     = r_pos;
        n_rcv     = r_rcv;
        n_cmp     = r_cmp;
        n_prev_ts = r_prev_ts;
        n_cmp_ts  = r_cmp_ts;

        n_res.status                 = ST_SHORT;
        n_res.position               = '0;
        n_res.payload_length         = '0;
        n_res.frame_done             = 1'b0;
        n_res.frame_packets_received = '0;
        n_res.frame_timestamp        = '0;

        go       = 1'b0;
        closed   = 1'b0;
        ok       = 1'b0;
        e_exp    = r_exp;
        e_pos    = r_pos;
        e_rcv    = r_rcv;
        e_cmp    = r_cmp;
        e_cmp_ts = r_cmp_ts;
        lost     = '0;
        pos_lost = '0;
        pos_inc  = '0;
        fp_wide  = {1'b0, i_cfg.frame_packets};
        dlen     = i_item.packet_length - HDR_BYTES;

        // Header sanity
        if (i_item.packet_length < HDR_BYTES) begin
            n_res.status = ST_SHORT;
        end else if (i_item.magic_first != MAGIC_A || i_item.magic_second != MAGIC_B) begin
            n_res.status = ST_BAD_MAGIC;
        end else if (!r_sync && i_item.flag_byte != sof) begin
            n_res.status = ST_UNSYNCED;
        end else begin
            go = 1'b1;
        end

        // Sync acquisition and skip over lost packets
        if (go) begin
            if (!r_sync) begin
                n_sync = 1'b1;
                e_exp  = i_item.seq_number;
                e_pos  = '0;
                e_rcv  = '0;
                e_cmp  = '0;
            end
            lost = i_item.seq_number - e_exp;
            if (lost > MAX_SKIP) begin
                n_sync       = 1'b0;
                n_res.status = ST_LOST;
                go           = 1'b0;
            end else if (lost != 8'd0) begin
                e_exp    = i_item.seq_number;
                pos_lost = {1'b0, e_pos} + {5'b0, lost};
                if (fp_wide <= pos_lost) begin
                    // the skip runs past the frame end and closes it
                    e_pos    = pos_lost[11:0] - i_cfg.frame_packets;
                    e_cmp    = e_rcv;
                    e_rcv    = '0;
                    e_cmp_ts = r_prev_ts;
                    closed   = 1'b1;
                end else begin
                    e_pos = pos_lost[11:0];
                end
            end
            n_exp    = e_exp;
            n_pos    = e_pos;
            n_rcv    = e_rcv;
            n_cmp    = e_cmp;
            n_cmp_ts = e_cmp_ts;
        end

        // Flag must fit the position in the frame
        if (go) begin
            pos_inc = {1'b0, e_pos} + 13'd1;
            ok = (e_pos == 12'd0 && i_item.flag_byte == sof) ||
                 (pos_inc == fp_wide && i_item.flag_byte == eof) ||
                 (e_pos != 12'd0 && pos_inc < fp_wide && i_item.flag_byte == mof);
            if (!ok) begin
                n_sync       = 1'b0;
                n_res.status = ST_FLAG;
                go           = 1'b0;
            end
        end

        if (go && dlen > i_cfg.payload_size) begin
            n_res.status = ST_OVERSIZE;
            go           = 1'b0;
        end

        // Accepted packet: advance and check for frame end
        if (go) begin
            n_res.status         = ST_ACCEPTED;
            n_res.position       = e_pos;
            n_res.payload_length = dlen;
            n_pos     = pos_inc[11:0];
            n_exp     = e_exp + 8'd1;
            n_rcv     = e_rcv + 12'd1;
            n_prev_ts = i_item.packet_timestamp;
            if (pos_inc[11:0] == i_cfg.frame_packets) begin
                n_pos    = '0;
                n_cmp    = e_rcv + 12'd1;
                n_rcv    = '0;
                n_cmp_ts = i_item.packet_timestamp;
                closed   = 1'b1;
            end
            if (closed) begin
                n_res.frame_done             = 1'b1;
                n_res.frame_packets_received = n_cmp;
                n_res.frame_timestamp        = n_cmp_ts;
            end
        end
    end

    // State and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync      <= 1'b0;
            r_exp       <= '0;
            r_pos       <= '0;
            r_rcv       <= '0;
            r_cmp       <= '0;
            r_prev_ts   <= '0;
            r_cmp_ts    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (take) begin
                r_sync    <= n_sync;
                r_exp     <= n_exp;
                r_pos     <= n_pos;
                r_rcv     <= n_rcv;
                r_cmp     <= n_cmp;
                r_prev_ts <= n_prev_ts;
                r_cmp_ts  <= n_cmp_ts;
                r_res     <= n_res;
            end
            if (o_ready) begin
                r_res_valid <= i_valid;
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

`ifndef ASSERT_OFF
    // A stalled result holds its contents
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && !i_out_ready |=> r_res_valid && $stable(r_res))
        else $error("result changed while stalled");

    // Frame completion only comes with an accepted packet
    a_done_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res.frame_done |-> r_res.status == ST_ACCEPTED)
        else $error("frame_done on a rejected packet");

    // A resync status leaves the tracker unsynced
    a_resync_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && (n_res.status == ST_LOST || n_res.status == ST_FLAG) |=> !r_sync)
        else $error("sync kept after resync status");

    // Only accepted packets carry a nonzero buffer position or payload length
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res.status != ST_ACCEPTED |-> r_res.position == 12'd0 &&
        r_res.payload_length == 12'd0)
        else $error("placement fields set on a rejected packet");
`endif

endmodule

`default_nettype wire

### rtl/cpd_out.sv
// Output stage: payload offset multiply and the master-side output register.
// Depends on cpd_pkg for the result and configuration types.
`default_nettype none

module cpd_out
    import cpd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_cfg       i_cfg,
    input  wire logic  i_valid,
    input  t_result    i_res,
    output logic       o_ready,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    output logic [79:0] m_tdata,   // write_offset, payload_length, frame_packets_received,
                                   // frame_timestamp
    output logic [2:0] m_tuser,    // status
    output logic       m_tlast     // frame_done
);

    logic        r_valid;
    logic [79:0] r_data;
    logic [2:0]  r_user;
    logic        r_last;
    logic [23:0] offset;

    assign o_ready = !r_valid || m_tready;

    // Position is zero for rejected packets, so the offset is too
    assign offset = {12'd0, i_res.position} * {12'd0, i_cfg.payload_size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= {i_res.frame_timestamp, i_res.frame_packets_received,
                       i_res.payload_length, offset};
            r_user <= i_res.status;
            r_last <= i_res.frame_done;
        end
    end

    assign m_tvalid = r_valid;
    assign m_tdata  = r_data;
    assign m_tuser  = r_user;
    assign m_tlast  = r_last;

endmodule

`default_nettype wire
